// File: hdl/kmsd_pkg.sv
// Package for the key matrix scanner with global debounce.
// Holds field widths, the reset constant and the lane control/status structs.
// No dependencies.
`default_nettype none

package kmsd_pkg;

  localparam int ROW_MAX = 8;
  localparam int COL_MAX = 16;

  localparam int COL_IDX_W = 4;
  localparam int ROW_IN_W  = 8;
  localparam int TIME_W    = 16;
  localparam int QROW_W    = 3;
  localparam int ROW_W     = 16;
  localparam int DB_MS_W   = 8;

  localparam logic [DB_MS_W-1:0] DEBOUNCE_RESET = 8'd5;

  typedef struct packed {
    logic             wr_en;
    logic             copy_en;
    logic [ROW_W-1:0] col_mask;
  } lane_ctl_t;

  typedef struct packed {
    logic             changed;
    logic [ROW_W-1:0] stable_row;
  } lane_stat_t;

endpackage

`default_nettype wire

// File: hdl/kmsd_if.sv
// Channel interfaces of the key matrix scanner: input items, results, config writes.
// Depends on kmsd_pkg.
`default_nettype none

interface kmsd_in_if;
  logic                           valid;
  logic                           ready;
  logic [kmsd_pkg::COL_IDX_W-1:0] column;
  logic [kmsd_pkg::ROW_IN_W-1:0]  row_bits;
  logic                           scan_end;
  logic [kmsd_pkg::TIME_W-1:0]    now_ms;
  logic [kmsd_pkg::QROW_W-1:0]    query_row;

  modport source (output valid, column, row_bits, scan_end, now_ms, query_row,
                  input ready);
  modport sink   (input valid, column, row_bits, scan_end, now_ms, query_row,
                  output ready);
  modport monitor (input valid, ready, column, row_bits, scan_end, now_ms, query_row);
endinterface

interface kmsd_out_if;
  logic                       valid;
  logic                       ready;
  logic [kmsd_pkg::ROW_W-1:0] debounced_row;
  logic                       all_keys_off;
  logic                       debounce_active;
  logic                       matrix_updated;

  modport source (output valid, debounced_row, all_keys_off, debounce_active,
                  matrix_updated, input ready);
  modport sink   (input valid, debounced_row, all_keys_off, debounce_active,
                  matrix_updated, output ready);
  modport monitor (input valid, ready, debounced_row, all_keys_off, debounce_active,
                   matrix_updated);
endinterface

interface kmsd_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [kmsd_pkg::DB_MS_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
  modport monitor (input valid, ready, data);
endinterface

`default_nettype wire

// File: hdl/kmsd_lane.sv
// One row lane: raw and debounced bits of a single matrix row.
// Depends on kmsd_pkg.
`default_nettype none

module kmsd_lane #(
  parameter int COLS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire kmsd_pkg::lane_ctl_t ctl,
  input  wire logic                row_bit,
  output kmsd_pkg::lane_stat_t     stat
);
  import kmsd_pkg::*;

  logic [COLS-1:0] raw_r, raw_nxt;
  logic [COLS-1:0] stable_r, stable_nxt;
  logic [COLS-1:0] mask;

  assign mask = ctl.col_mask[COLS-1:0];

  always_comb begin
    raw_nxt    = raw_r;
    stable_nxt = stable_r;
    if (ctl.wr_en) begin
      raw_nxt = row_bit ? (raw_r | mask) : (raw_r & ~mask);
    end
    if (ctl.copy_en) begin
      stable_nxt = raw_nxt;
    end
  end

  assign stat.changed    = ctl.wr_en && (raw_nxt != raw_r);
  assign stat.stable_row = ROW_W'(stable_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r    <= '0;
      stable_r <= '0;
    end else begin
      raw_r    <= raw_nxt;
      stable_r <= stable_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/kmsd_merge.sv
// Merge stage: combines lane change flags, runs the debounce timer,
// drives lane controls and the registered result. Depends on kmsd_pkg, kmsd_if.
`default_nettype none

module kmsd_merge #(
  parameter int ROWS = 8,
  parameter int COLS = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  kmsd_in_if.sink                                        in_ch,
  kmsd_out_if.source                                     out_ch,
  kmsd_cfg_if.sink                                       cfg_ch,
  input  wire kmsd_pkg::lane_stat_t [kmsd_pkg::ROW_MAX-1:0] lane_stat,
  output kmsd_pkg::lane_ctl_t                            lane_ctl
);
  import kmsd_pkg::*;

  logic               accept;
  logic               last;
  logic               any_change;
  logic               all_off;
  logic               start;
  logic               copy;
  logic [TIME_W-1:0]  elapsed;
  logic [ROW_W-1:0]   qrow;

  logic               running_r, running_nxt;
  logic [TIME_W-1:0]  start_r, start_nxt;
  logic               changed_r, changed_nxt;
  logic [DB_MS_W-1:0] db_ms_r, db_ms_nxt;

  logic               ovalid_r, ovalid_nxt;
  logic [ROW_W-1:0]   orow_r, orow_nxt;
  logic               ooff_r, ooff_nxt;
  logic               oact_r, oact_nxt;
  logic               oupd_r, oupd_nxt;

  assign in_ch.ready  = !ovalid_r || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign last         = accept && in_ch.scan_end;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    any_change = 1'b0;
    all_off    = 1'b1;
    for (int r = 0; r < ROW_MAX; r++) begin
      any_change = any_change | lane_stat[r].changed;
      all_off    = all_off & (lane_stat[r].stable_row == '0);
    end
  end

  assign qrow = ({1'b0, in_ch.query_row} < (QROW_W + 1)'(ROWS)) ?
                lane_stat[in_ch.query_row].stable_row : '0;

  assign elapsed = in_ch.now_ms - start_r;
  assign start   = last && (changed_r || any_change) && !running_r;
  assign copy    = last && running_r && (elapsed > TIME_W'(db_ms_r));

  always_comb begin
    lane_ctl.wr_en    = accept;
    lane_ctl.copy_en  = copy;
    lane_ctl.col_mask = ({1'b0, in_ch.column} < (COL_IDX_W + 1)'(COLS)) ?
                        (ROW_W'(1) << in_ch.column) : '0;
  end

  always_comb begin
    running_nxt = running_r;
    start_nxt   = start_r;
    changed_nxt = changed_r;
    db_ms_nxt   = cfg_ch.valid ? cfg_ch.data : db_ms_r;
    if (start) begin
      running_nxt = 1'b1;
      start_nxt   = in_ch.now_ms;
    end
    if (copy) begin
      running_nxt = 1'b0;
    end
    if (accept) begin
      changed_nxt = last ? 1'b0 : (changed_r | any_change);
    end
  end

  always_comb begin
    ovalid_nxt = ovalid_r && !out_ch.ready;
    orow_nxt   = orow_r;
    ooff_nxt   = ooff_r;
    oact_nxt   = oact_r;
    oupd_nxt   = oupd_r;
    if (accept) begin
      ovalid_nxt = 1'b1;
      orow_nxt   = qrow;
      ooff_nxt   = all_off;
      oact_nxt   = running_nxt;
      oupd_nxt   = copy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      start_r   <= '0;
      changed_r <= 1'b0;
      db_ms_r   <= DEBOUNCE_RESET;
      ovalid_r  <= 1'b0;
    end else begin
      running_r <= running_nxt;
      start_r   <= start_nxt;
      changed_r <= changed_nxt;
      db_ms_r   <= db_ms_nxt;
      ovalid_r  <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    orow_r <= orow_nxt;
    ooff_r <= ooff_nxt;
    oact_r <= oact_nxt;
    oupd_r <= oupd_nxt;
  end

  assign out_ch.valid           = ovalid_r;
  assign out_ch.debounced_row   = orow_r;
  assign out_ch.all_keys_off    = ooff_r;
  assign out_ch.debounce_active = oact_r;
  assign out_ch.matrix_updated  = oupd_r;

endmodule

`default_nettype wire

// File: hdl/key_matrix_scan_debounce.sv
// Top level of the key matrix scanner with one global debounce timer.
// Depends on kmsd_pkg, kmsd_if, kmsd_lane, kmsd_merge.
//
//   channel  | dir | payload                                               | handshake
//   in_ch    | in  | column, row_bits, scan_end, now_ms, query_row         | valid/ready
//   out_ch   | out | debounced_row, all_keys_off, debounce_active,         | valid/ready
//            |     | matrix_updated                                        |
//   cfg_ch   | in  | data = debounce_ms                                    | valid/ready
//
// One item per cycle: all row lanes update in the accepting cycle, and the
// result sits in the output register on the next cycle.
// in_ch.ready drops only while a result waits and out_ch.ready is low.
// cfg_ch.ready is always high. Synchronous reset clears both matrices,
// the timer state and the output valid; debounce_ms resets to 5.
`default_nettype none

module key_matrix_scan_debounce #(
  parameter int ROWS = 8,
  parameter int COLS = 16
) (
  input wire logic   clk,
  input wire logic   rst_n,
  kmsd_in_if.sink    in_ch,
  kmsd_out_if.source out_ch,
  kmsd_cfg_if.sink   cfg_ch
);
  import kmsd_pkg::*;

  lane_ctl_t                 lane_ctl;
  lane_stat_t [ROW_MAX-1:0]  lane_stat;

  for (genvar r = 0; r < ROW_MAX; r++) begin : g_lane
    if (r < ROWS) begin : g_on
      kmsd_lane #(.COLS(COLS)) u_lane (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (lane_ctl),
        .row_bit (in_ch.row_bits[r]),
        .stat    (lane_stat[r])
      );
    end else begin : g_off
      assign lane_stat[r] = '0;
    end
  end

  kmsd_merge #(.ROWS(ROWS), .COLS(COLS)) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_ch    (cfg_ch),
    .lane_stat (lane_stat),
    .lane_ctl  (lane_ctl)
  );

endmodule

`default_nettype wire

// File: hdl/kmsd_checker.sv
// Port-level checks for the key matrix scanner, bound to the top level.
// Depends on kmsd_if and key_matrix_scan_debounce.
`default_nettype none

module kmsd_checker (
  input wire logic   clk,
  input wire logic   rst_n,
  kmsd_in_if.sink    in_ch,
  kmsd_out_if.source out_ch
);

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> out_ch.valid)
    else $error("accepted item gave no result");

  a_no_copy_mid_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && !in_ch.scan_end) |=> !out_ch.matrix_updated)
    else $error("matrix copied on a step without scan end");

  a_copy_ends_interval: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.matrix_updated) |-> !out_ch.debounce_active)
    else $error("interval still running after copy");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=>
      (out_ch.valid && $stable(out_ch.debounced_row) && $stable(out_ch.matrix_updated)))
    else $error("stalled result changed");

endmodule

bind key_matrix_scan_debounce kmsd_checker u_kmsd_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

`default_nettype wire

// File: test/tb_key_matrix_scan_debounce.sv
// Self-checking testbench for key_matrix_scan_debounce: directed scans, then random passes.
// A class tracks the raw and debounced matrices and checks every result in order.
// Depends on kmsd_pkg, kmsd_if and the block's RTL.
`default_nettype none

typedef struct packed {
  logic [kmsd_pkg::COL_IDX_W-1:0] column;
  logic [kmsd_pkg::ROW_IN_W-1:0]  row_bits;
  logic                           scan_end;
  logic [kmsd_pkg::TIME_W-1:0]    now_ms;
  logic [kmsd_pkg::QROW_W-1:0]    query_row;
} scan_sample_t;

typedef struct packed {
  logic [kmsd_pkg::ROW_W-1:0] debounced_row;
  logic                       all_keys_off;
  logic                       debounce_active;
  logic                       matrix_updated;
} key_report_t;

class matrix_tracker;
  logic [kmsd_pkg::ROW_W-1:0]   raw_rows[kmsd_pkg::ROW_MAX];
  logic [kmsd_pkg::ROW_W-1:0]   stable_rows[kmsd_pkg::ROW_MAX];
  bit                           interval_on;
  logic [kmsd_pkg::TIME_W-1:0]  interval_start;
  bit                           pass_changed;
  logic [kmsd_pkg::DB_MS_W-1:0] debounce_ms;
  key_report_t                  expected_reports[$];
  int                           errors;
  int                           samples;
  int                           reports;
  int                           copies;

  function new();
    int r;
    for (r = 0; r < kmsd_pkg::ROW_MAX; r++) begin
      raw_rows[r] = '0;
      stable_rows[r] = '0;
    end
    interval_on = 0;
    interval_start = '0;
    pass_changed = 0;
    debounce_ms = kmsd_pkg::DEBOUNCE_RESET;
    errors = 0;
    samples = 0;
    reports = 0;
    copies = 0;
  endfunction

  function void set_debounce(logic [kmsd_pkg::DB_MS_W-1:0] value);
    debounce_ms = value;
  endfunction

  function void note_sample(scan_sample_t s);
    logic [kmsd_pkg::ROW_W-1:0]  col_bit;
    logic [kmsd_pkg::ROW_W-1:0]  next_row;
    logic [kmsd_pkg::TIME_W-1:0] elapsed;
    key_report_t                 e;
    int                          r;
    e = '0;
    samples++;
    if (int'(s.column) < kmsd_pkg::COL_MAX) begin
      col_bit = kmsd_pkg::ROW_W'(1) << s.column;
      for (r = 0; r < kmsd_pkg::ROW_MAX; r++) begin
        next_row = s.row_bits[r] ? (raw_rows[r] | col_bit) : (raw_rows[r] & ~col_bit);
        if (next_row != raw_rows[r]) begin
          raw_rows[r] = next_row;
          pass_changed = 1;
        end
      end
    end
    if (s.scan_end) begin
      if (pass_changed && !interval_on) begin
        interval_on = 1;
        interval_start = s.now_ms;
      end
      pass_changed = 0;
      if (interval_on) begin
        elapsed = s.now_ms - interval_start;
        if (elapsed > kmsd_pkg::TIME_W'(debounce_ms)) begin
          for (r = 0; r < kmsd_pkg::ROW_MAX; r++) stable_rows[r] = raw_rows[r];
          interval_on = 0;
          e.matrix_updated = 1'b1;
        end
      end
    end
    e.all_keys_off = 1'b1;
    for (r = 0; r < kmsd_pkg::ROW_MAX; r++)
      if (stable_rows[r] != '0) e.all_keys_off = 1'b0;
    if (int'(s.query_row) < kmsd_pkg::ROW_MAX) e.debounced_row = stable_rows[s.query_row];
    e.debounce_active = interval_on;
    expected_reports.push_back(e);
  endfunction

  function void check_report(key_report_t got);
    key_report_t e;
    if (expected_reports.size() == 0) begin
      errors++;
      $display("%0t: unexpected result row=%h off=%b active=%b updated=%b", $time,
               got.debounced_row, got.all_keys_off, got.debounce_active, got.matrix_updated);
      return;
    end
    e = expected_reports.pop_front();
    reports++;
    if (e.matrix_updated) copies++;
    if (got.debounced_row !== e.debounced_row || got.all_keys_off !== e.all_keys_off ||
        got.debounce_active !== e.debounce_active || got.matrix_updated !== e.matrix_updated) begin
      errors++;
      $display("%0t: mismatch exp row=%h off=%b active=%b updated=%b got row=%h off=%b active=%b updated=%b",
               $time, e.debounced_row, e.all_keys_off, e.debounce_active, e.matrix_updated,
               got.debounced_row, got.all_keys_off, got.debounce_active, got.matrix_updated);
    end
  endfunction

  function int pending();
    return expected_reports.size();
  endfunction
endclass

module tb_key_matrix_scan_debounce;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk;
  logic rst_n;

  kmsd_in_if  in_ch();
  kmsd_out_if out_ch();
  kmsd_cfg_if cfg_ch();

  key_matrix_scan_debounce i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  matrix_tracker                tracker;
  bit                           src_calm;
  bit                           sink_calm;
  int                           idle_cycles;
  int                           settings_seen;
  logic [kmsd_pkg::TIME_W-1:0]  now_t;
  logic [kmsd_pkg::DB_MS_W-1:0] db_setting;
  logic [kmsd_pkg::ROW_IN_W-1:0] col_rows[kmsd_pkg::COL_MAX];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_calm) begin
        out_ch.ready <= 1'b1;
        hold = 0;
      end else if (hold > 0) begin
        hold--;
      end else begin
        case ($urandom_range(0, 19))
          0: begin
            out_ch.ready <= 1'b0;
            hold = $urandom_range(15, 50);
          end
          1, 2, 3, 4, 5, 6, 7: begin
            out_ch.ready <= 1'b0;
            hold = $urandom_range(0, 3);
          end
          default: begin
            out_ch.ready <= 1'b1;
            hold = $urandom_range(0, 8);
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) tracker.set_debounce(cfg_ch.data);
      if (out_ch.valid && out_ch.ready)
        tracker.check_report({out_ch.debounced_row, out_ch.all_keys_off,
                              out_ch.debounce_active, out_ch.matrix_updated});
      if (in_ch.valid && in_ch.ready)
        tracker.note_sample({in_ch.column, in_ch.row_bits, in_ch.scan_end,
                             in_ch.now_ms, in_ch.query_row});
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (src_calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_sample(input logic [kmsd_pkg::COL_IDX_W-1:0] col,
                             input logic [kmsd_pkg::ROW_IN_W-1:0] rows,
                             input logic last,
                             input logic [kmsd_pkg::TIME_W-1:0] now,
                             input logic [kmsd_pkg::QROW_W-1:0] q);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.column    <= col;
    in_ch.row_bits  <= rows;
    in_ch.scan_end  <= last;
    in_ch.now_ms    <= now;
    in_ch.query_row <= q;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (tracker.pending() > 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_debounce(input logic [kmsd_pkg::DB_MS_W-1:0] value);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    db_setting = value;
    settings_seen++;
  endtask

  task automatic run_scans(input int n_scans);
    int s;
    int c;
    int k;
    int n_noise;
    logic [kmsd_pkg::ROW_IN_W-1:0] rows;
    for (s = 0; s < n_scans; s++) begin
      if ($urandom_range(0, 4) == 0) begin
        n_noise = $urandom_range(1, 4);
        for (k = 0; k < n_noise; k++) begin
          now_t += kmsd_pkg::TIME_W'($urandom_range(0, 300));
          send_sample(kmsd_pkg::COL_IDX_W'($urandom), kmsd_pkg::ROW_IN_W'($urandom),
                      1'($urandom), now_t, kmsd_pkg::QROW_W'($urandom));
        end
      end
      k = $urandom_range(0, kmsd_pkg::COL_MAX - 1);
      case ($urandom_range(0, 9))
        0, 1, 2: col_rows[k] ^= kmsd_pkg::ROW_IN_W'(1 << $urandom_range(0, 7));
        3: col_rows[k] = kmsd_pkg::ROW_IN_W'($urandom);
        4: for (c = 0; c < kmsd_pkg::COL_MAX; c++) col_rows[c] = '0;
        default: ;
      endcase
      for (c = 0; c < kmsd_pkg::COL_MAX; c++) begin
        rows = col_rows[c];
        if ($urandom_range(0, 19) == 0) rows ^= kmsd_pkg::ROW_IN_W'($urandom);
        now_t += kmsd_pkg::TIME_W'($urandom_range(0, 1));
        if (c == kmsd_pkg::COL_MAX - 1) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: now_t += kmsd_pkg::TIME_W'($urandom_range(0, 3));
            9: now_t += kmsd_pkg::TIME_W'($urandom);
            default: now_t += kmsd_pkg::TIME_W'($urandom_range(0, int'(db_setting) + 3));
          endcase
        end
        send_sample(kmsd_pkg::COL_IDX_W'(c), rows, c == kmsd_pkg::COL_MAX - 1, now_t,
                    kmsd_pkg::QROW_W'($urandom_range(0, kmsd_pkg::ROW_MAX - 1)));
      end
    end
  endtask

  initial begin
    int c;
    tracker = new();
    src_calm = 0;
    sink_calm = 0;
    idle_cycles = 0;
    settings_seen = 0;
    db_setting = kmsd_pkg::DEBOUNCE_RESET;
    now_t = kmsd_pkg::TIME_W'($urandom);
    for (c = 0; c < kmsd_pkg::COL_MAX; c++) col_rows[c] = kmsd_pkg::ROW_IN_W'($urandom);
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.column = '0;
    in_ch.row_bits = '0;
    in_ch.scan_end = 1'b0;
    in_ch.now_ms = '0;
    in_ch.query_row = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    send_sample(4'd0, 8'hFF, 1'b0, 16'd0, 3'd0);
    send_sample(4'd15, 8'h01, 1'b0, 16'd2000, 3'd7);
    send_sample(4'd3, 8'h00, 1'b1, 16'd100, 3'd0);
    send_sample(4'd3, 8'h00, 1'b0, 16'd900, 3'd1);
    send_sample(4'd3, 8'h00, 1'b1, 16'd105, 3'd2);
    send_sample(4'd3, 8'h00, 1'b1, 16'd106, 3'd0);
    for (c = 1; c < kmsd_pkg::ROW_MAX; c++)
      send_sample(4'd7, 8'h00, 1'b0, 16'd106, kmsd_pkg::QROW_W'(c));
    send_sample(4'd0, 8'h00, 1'b0, 16'd200, 3'd0);
    send_sample(4'd15, 8'h00, 1'b1, 16'd65534, 3'd0);
    send_sample(4'd15, 8'h00, 1'b1, 16'd3, 3'd3);
    send_sample(4'd15, 8'h00, 1'b1, 16'd4, 3'd0);
    send_sample(4'd15, 8'hFF, 1'b1, 16'd65535, 3'd7);
    send_sample(4'd15, 8'hFF, 1'b1, 16'd6, 3'd7);
    send_sample(4'd15, 8'h00, 1'b0, 16'd7, 3'd0);
    send_sample(4'd8, 8'hAA, 1'b1, 16'd20, 3'd5);
    send_sample(4'd8, 8'hAA, 1'b1, 16'd30, 3'd5);

    write_debounce(8'd0);
    run_scans(6);
    write_debounce(8'd255);
    src_calm = 1;
    sink_calm = 1;
    run_scans(2);
    src_calm = 0;
    sink_calm = 0;
    run_scans(5);
    write_debounce(kmsd_pkg::DB_MS_W'($urandom_range(1, 254)));
    run_scans(6);
    write_debounce(kmsd_pkg::DEBOUNCE_RESET);
    src_calm = 1;
    run_scans(3);
    src_calm = 0;
    run_scans(3);

    drain();
    $display("Ran %0d scan items over %0d debounce settings: %0d results, %0d matrix copies.",
             tracker.samples, settings_seen + 1, tracker.reports, tracker.copies);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule

`default_nettype wire
